>>> rtl/core/lchws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lchws_pkg
// Shared types, codes and helpers for the lock class hold/wait statistics block.
// ----------------------------------------------------------------------------
package lchws_pkg;

    localparam int CLASS_ENTRIES_DEF = 64;
    localparam int STACK_ENTRIES_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int INST_W   = 32;
    localparam int TIME_W   = 48;
    localparam int CIDX_W   = 6;
    localparam int STATUS_W = 4;
    localparam int CLSO_W   = 6;
    localparam int DEPTHO_W = 6;
    localparam int TOTAL_W  = 64;
    localparam int COUNT_W  = 32;

    localparam logic [CMD_W-1:0] CMD_REGISTER  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACQUIRE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTENDED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACQUIRED  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd6;

    localparam logic [STATUS_W-1:0] STS_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] STS_DUPLICATE = 4'd1;
    localparam logic [STATUS_W-1:0] STS_TBL_FULL  = 4'd2;
    localparam logic [STATUS_W-1:0] STS_UNKNOWN   = 4'd3;
    localparam logic [STATUS_W-1:0] STS_STK_FULL  = 4'd4;
    localparam logic [STATUS_W-1:0] STS_STK_EMPTY = 4'd5;
    localparam logic [STATUS_W-1:0] STS_NOT_HELD  = 4'd6;
    localparam logic [STATUS_W-1:0] STS_DISABLED  = 4'd7;
    localparam logic [STATUS_W-1:0] STS_NULL_KEY  = 4'd8;
    localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 4'd9;

    typedef struct packed {
        logic [TIME_W-1:0]  min;
        logic [TIME_W-1:0]  max;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } stat_t;

    typedef struct packed {
        stat_t wait_s;
        stat_t hold_s;
    } class_stat_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_K_RD, S_K_CMP, S_S_RD, S_S_CMP,
        S_F_RD, S_UPD, S_CLR, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_KSTART, OP_KNEXT, OP_KFOUND, OP_KREG, OP_PUSH,
        OP_SSTART, OP_SNEXT, OP_SHIT, OP_CLSIDX, OP_UPD, OP_CLR_START, OP_CLR,
        OP_FAIL, OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic                in_ready;
        logic                key_sel;
        dp_op_t              op;
        logic [STATUS_W-1:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic             accept;
        logic [CMD_W-1:0] command;
        logic             key_zero;
        logic             stats_en;
        logic             count_zero;
        logic             tbl_full;
        logic             stk_empty;
        logic             stk_full;
        logic             cidx_bad;
        logic             k_match;
        logic             k_last;
        logic             s_match;
        logic             s_last;
        logic             clr_last;
        logic             out_free;
    } dp_stat_t;

    function automatic stat_t stat_add(stat_t s, logic [TIME_W-1:0] t);
        stat_t r;
        r = s;
        if (t < s.min || s.count == '0)
            r.min = t;
        if (t > s.max)
            r.max = t;
        r.total = s.total + TOTAL_W'(t);
        if (s.count != '1)
            r.count = s.count + 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lchws_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lchws_if
// Event, result and configuration channels (valid/ready).
// ----------------------------------------------------------------------------
interface lchws_evt_if;
    logic                         valid;
    logic                         ready;
    logic [lchws_pkg::CMD_W-1:0]  command;
    logic [lchws_pkg::KEY_W-1:0]  lock_key;
    logic [lchws_pkg::INST_W-1:0] lock_instance;
    logic [lchws_pkg::TIME_W-1:0] timestamp;
    logic [lchws_pkg::CIDX_W-1:0] class_index;
    modport source (output valid, command, lock_key, lock_instance, timestamp, class_index,
                    input ready);
    modport sink (input valid, command, lock_key, lock_instance, timestamp, class_index,
                  output ready);
endinterface

interface lchws_res_if;
    logic                           valid;
    logic                           ready;
    logic [lchws_pkg::STATUS_W-1:0] status;
    logic [lchws_pkg::CLSO_W-1:0]   result_class;
    logic [lchws_pkg::DEPTHO_W-1:0] depth_now;
    logic [lchws_pkg::KEY_W-1:0]    out_key;
    logic [lchws_pkg::TIME_W-1:0]   wait_min_out;
    logic [lchws_pkg::TIME_W-1:0]   wait_max_out;
    logic [lchws_pkg::TOTAL_W-1:0]  wait_total_out;
    logic [lchws_pkg::COUNT_W-1:0]  wait_count_out;
    logic [lchws_pkg::TIME_W-1:0]   hold_min_out;
    logic [lchws_pkg::TIME_W-1:0]   hold_max_out;
    logic [lchws_pkg::TOTAL_W-1:0]  hold_total_out;
    logic [lchws_pkg::COUNT_W-1:0]  hold_count_out;
    modport source (output valid, status, result_class, depth_now, out_key, wait_min_out,
                    wait_max_out, wait_total_out, wait_count_out, hold_min_out,
                    hold_max_out, hold_total_out, hold_count_out, input ready);
    modport sink (input valid, status, result_class, depth_now, out_key, wait_min_out,
                  wait_max_out, wait_total_out, wait_count_out, hold_min_out,
                  hold_max_out, hold_total_out, hold_count_out, output ready);
endinterface

interface lchws_cfg_if;
    logic valid;
    logic ready;
    logic stats_enable;
    modport source (output valid, stats_enable, input ready);
    modport sink (input valid, stats_enable, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lchws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lchws_ctrl
// Sequencer: decodes each request and steps the datapath through searches.
// ----------------------------------------------------------------------------
module lchws_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lchws_pkg::dp_stat_t st,
    output lchws_pkg::dp_cmd_t      cmd
);

    lchws_pkg::state_t state_reg;
    lchws_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lchws_pkg::S_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.in_ready = 1'b0;
        cmd.key_sel  = 1'b0;
        cmd.op       = lchws_pkg::OP_NONE;
        cmd.code     = lchws_pkg::STS_OK;
        unique case (state_reg)
            lchws_pkg::S_INIT:
            begin
                cmd.op = lchws_pkg::OP_CLR;
                if (st.clr_last)
                    state_next = lchws_pkg::S_IDLE;
            end
            lchws_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.op       = lchws_pkg::OP_LATCH;
                if (st.accept)
                    state_next = lchws_pkg::S_DECODE;
            end
            lchws_pkg::S_DECODE:
            begin
                priority if (st.command == lchws_pkg::CMD_REGISTER ||
                             st.command == lchws_pkg::CMD_ACQUIRE)
                begin
                    if (st.key_zero)
                    begin
                        cmd.op     = lchws_pkg::OP_FAIL;
                        cmd.code   = lchws_pkg::STS_NULL_KEY;
                        state_next = lchws_pkg::S_DONE;
                    end
                    else if (!st.count_zero)
                    begin
                        cmd.op     = lchws_pkg::OP_KSTART;
                        state_next = lchws_pkg::S_K_RD;
                    end
                    else if (st.command == lchws_pkg::CMD_REGISTER)
                    begin
                        cmd.op     = lchws_pkg::OP_KREG;
                        state_next = lchws_pkg::S_F_RD;
                    end
                    else
                    begin
                        cmd.op     = lchws_pkg::OP_FAIL;
                        cmd.code   = lchws_pkg::STS_UNKNOWN;
                        state_next = lchws_pkg::S_DONE;
                    end
                end
                else if (st.command == lchws_pkg::CMD_RELEASE ||
                         st.command == lchws_pkg::CMD_CONTENDED ||
                         st.command == lchws_pkg::CMD_ACQUIRED)
                begin
                    if (st.command != lchws_pkg::CMD_RELEASE && !st.stats_en)
                    begin
                        cmd.op     = lchws_pkg::OP_FAIL;
                        cmd.code   = lchws_pkg::STS_DISABLED;
                        state_next = lchws_pkg::S_DONE;
                    end
                    else if (st.stk_empty)
                    begin
                        cmd.op     = lchws_pkg::OP_FAIL;
                        cmd.code   = lchws_pkg::STS_STK_EMPTY;
                        state_next = lchws_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.op     = lchws_pkg::OP_SSTART;
                        state_next = lchws_pkg::S_S_RD;
                    end
                end
                else if (st.command == lchws_pkg::CMD_READ)
                begin
                    if (st.cidx_bad)
                    begin
                        cmd.op     = lchws_pkg::OP_FAIL;
                        cmd.code   = lchws_pkg::STS_BAD_INDEX;
                        state_next = lchws_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.op     = lchws_pkg::OP_CLSIDX;
                        state_next = lchws_pkg::S_F_RD;
                    end
                end
                else if (st.command == lchws_pkg::CMD_CLEAR)
                begin
                    cmd.op     = lchws_pkg::OP_CLR_START;
                    state_next = lchws_pkg::S_CLR;
                end
                else
                begin
                    cmd.op     = lchws_pkg::OP_FAIL;
                    cmd.code   = lchws_pkg::STS_OK;
                    state_next = lchws_pkg::S_DONE;
                end
            end
            lchws_pkg::S_K_RD:
            begin
                cmd.key_sel = 1'b1;
                state_next  = lchws_pkg::S_K_CMP;
            end
            lchws_pkg::S_K_CMP:
            begin
                priority if (st.k_match)
                begin
                    if (st.command == lchws_pkg::CMD_REGISTER)
                    begin
                        cmd.op     = lchws_pkg::OP_KFOUND;
                        cmd.code   = lchws_pkg::STS_DUPLICATE;
                        state_next = lchws_pkg::S_F_RD;
                    end
                    else if (st.stk_full)
                    begin
                        cmd.op     = lchws_pkg::OP_FAIL;
                        cmd.code   = lchws_pkg::STS_STK_FULL;
                        state_next = lchws_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.op     = lchws_pkg::OP_PUSH;
                        state_next = lchws_pkg::S_F_RD;
                    end
                end
                else if (st.k_last)
                begin
                    if (st.command == lchws_pkg::CMD_REGISTER && !st.tbl_full)
                    begin
                        cmd.op     = lchws_pkg::OP_KREG;
                        state_next = lchws_pkg::S_F_RD;
                    end
                    else
                    begin
                        cmd.op     = lchws_pkg::OP_FAIL;
                        cmd.code   = (st.command == lchws_pkg::CMD_REGISTER) ?
                                     lchws_pkg::STS_TBL_FULL : lchws_pkg::STS_UNKNOWN;
                        state_next = lchws_pkg::S_DONE;
                    end
                end
                else
                begin
                    cmd.op     = lchws_pkg::OP_KNEXT;
                    state_next = lchws_pkg::S_K_RD;
                end
            end
            lchws_pkg::S_S_RD:
            begin
                state_next = lchws_pkg::S_S_CMP;
            end
            lchws_pkg::S_S_CMP:
            begin
                priority if (st.s_match)
                begin
                    cmd.op     = lchws_pkg::OP_SHIT;
                    state_next = lchws_pkg::S_F_RD;
                end
                else if (st.s_last)
                begin
                    cmd.op     = lchws_pkg::OP_FAIL;
                    cmd.code   = lchws_pkg::STS_NOT_HELD;
                    state_next = lchws_pkg::S_DONE;
                end
                else
                begin
                    cmd.op     = lchws_pkg::OP_SNEXT;
                    state_next = lchws_pkg::S_S_RD;
                end
            end
            lchws_pkg::S_F_RD:
            begin
                state_next = lchws_pkg::S_UPD;
            end
            lchws_pkg::S_UPD:
            begin
                cmd.op     = lchws_pkg::OP_UPD;
                state_next = lchws_pkg::S_DONE;
            end
            lchws_pkg::S_CLR:
            begin
                cmd.op = lchws_pkg::OP_CLR;
                if (st.clr_last)
                    state_next = lchws_pkg::S_DONE;
            end
            lchws_pkg::S_DONE:
            begin
                // hold the finished result here until the output register frees up
                if (st.out_free)
                begin
                    cmd.op     = lchws_pkg::OP_OUT;
                    state_next = lchws_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lchws_pkg::S_INIT;
            end
        endcase
    end

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lchws_pkg::S_IDLE && st.accept) |=> state_reg == lchws_pkg::S_DECODE)
        else $error("accepted request not decoded");

    a_upd_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lchws_pkg::S_UPD |-> $past(state_reg) == lchws_pkg::S_F_RD)
        else $error("stats update without fetch");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.in_ready |-> state_reg == lchws_pkg::S_IDLE)
        else $error("ready outside idle");

endmodule
`default_nettype wire

>>> rtl/core/lchws_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lchws_dp
// Datapath: class key table, held-lock stack, per-class stats memory, output.
// ----------------------------------------------------------------------------
module lchws_dp #(
    parameter int CLASS_ENTRIES = lchws_pkg::CLASS_ENTRIES_DEF,
    parameter int STACK_ENTRIES = lchws_pkg::STACK_ENTRIES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lchws_evt_if.sink              evt,
    lchws_res_if.source            res,
    lchws_cfg_if.sink              cfg,
    input  wire lchws_pkg::dp_cmd_t cmd,
    output lchws_pkg::dp_stat_t    st
);

    localparam int CW = $clog2(CLASS_ENTRIES);
    localparam int SW = $clog2(STACK_ENTRIES);
    localparam int XW = (CW + 1 > lchws_pkg::CIDX_W) ? CW + 1 : lchws_pkg::CIDX_W;
    localparam int TW = lchws_pkg::TIME_W;

    typedef struct packed {
        logic [CW-1:0]                cls;
        logic [lchws_pkg::INST_W-1:0] inst;
        logic [TW-1:0]                wait_stamp;
        logic                         wait_valid;
        logic [TW-1:0]                hold_stamp;
    } held_t;

    // memories
    logic [lchws_pkg::KEY_W-1:0] key_mem [CLASS_ENTRIES];
    held_t                       stk_mem [STACK_ENTRIES];
    lchws_pkg::class_stat_t      stat_mem [CLASS_ENTRIES];

    logic [lchws_pkg::KEY_W-1:0] key_rd_reg;
    held_t                       stk_rd_reg;
    lchws_pkg::class_stat_t      stat_rd_reg;

    // request fields
    logic [lchws_pkg::CMD_W-1:0]  cmd_reg;
    logic [lchws_pkg::KEY_W-1:0]  key_reg;
    logic [lchws_pkg::INST_W-1:0] inst_reg;
    logic [TW-1:0]                now_reg;
    logic [lchws_pkg::CIDX_W-1:0] cidx_reg;

    // control state
    logic                 en_reg;
    logic [CW:0]          count_reg;
    logic [SW:0]          depth_reg;
    logic [CW-1:0]        cptr_reg;
    logic [SW-1:0]        sptr_reg;
    logic [CW-1:0]        cls_reg;
    logic                 has_cls_reg;
    logic [lchws_pkg::STATUS_W-1:0] status_reg;
    logic                 upd_wait_reg;
    logic                 upd_hold_reg;
    logic [TW-1:0]        t_reg;
    logic                 out_valid_reg;

    lchws_pkg::class_stat_t      res_stat_reg;
    logic [lchws_pkg::KEY_W-1:0] res_key_reg;

    lchws_pkg::class_stat_t      stat_new;
    logic [CW-1:0]               key_addr;
    logic [TW-1:0]               hold_diff;
    logic [TW-1:0]               wait_diff;
    held_t                       stk_wr;
    logic                        accept;

    assign accept   = evt.valid && cmd.in_ready;
    assign evt.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;
    assign key_addr  = cmd.key_sel ? cptr_reg : cls_reg;
    assign hold_diff = now_reg - stk_rd_reg.hold_stamp;
    assign wait_diff = now_reg - stk_rd_reg.wait_stamp;

    always_comb
    begin
        stat_new = stat_rd_reg;
        if (upd_wait_reg)
            stat_new.wait_s = lchws_pkg::stat_add(stat_rd_reg.wait_s, t_reg);
        if (upd_hold_reg)
            stat_new.hold_s = lchws_pkg::stat_add(stat_rd_reg.hold_s, t_reg);
    end

    always_comb
    begin
        stk_wr = stk_rd_reg;
        if (cmd.op == lchws_pkg::OP_PUSH)
        begin
            stk_wr.cls        = cptr_reg;
            stk_wr.inst       = inst_reg;
            stk_wr.wait_stamp = '0;
            stk_wr.wait_valid = 1'b0;
            stk_wr.hold_stamp = now_reg;
        end
        else if (cmd_reg == lchws_pkg::CMD_CONTENDED)
        begin
            stk_wr.wait_stamp = now_reg;
            stk_wr.wait_valid = 1'b1;
        end
        else
        begin
            stk_wr.hold_stamp = now_reg;
        end
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[key_addr];
        stk_rd_reg  <= stk_mem[sptr_reg];
        stat_rd_reg <= stat_mem[cls_reg];
        if (cmd.op == lchws_pkg::OP_KREG)
            key_mem[count_reg[CW-1:0]] <= key_reg;
        if (cmd.op == lchws_pkg::OP_PUSH)
            stk_mem[depth_reg[SW-1:0]] <= stk_wr;
        else if (cmd.op == lchws_pkg::OP_SHIT &&
                 (cmd_reg == lchws_pkg::CMD_CONTENDED ||
                  (cmd_reg == lchws_pkg::CMD_ACQUIRED && stk_rd_reg.wait_valid)))
            stk_mem[sptr_reg] <= stk_wr;
        if (cmd.op == lchws_pkg::OP_UPD)
            stat_mem[cls_reg] <= stat_new;
        else if (cmd.op == lchws_pkg::OP_CLR)
            stat_mem[cptr_reg] <= '0;
    end

    // request payload and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == lchws_pkg::OP_LATCH && accept)
        begin
            cmd_reg  <= evt.command;
            key_reg  <= evt.lock_key;
            inst_reg <= evt.lock_instance;
            now_reg  <= evt.timestamp;
            cidx_reg <= evt.class_index;
        end
        if (cmd.op == lchws_pkg::OP_SHIT)
            t_reg <= (cmd_reg == lchws_pkg::CMD_RELEASE) ? hold_diff : wait_diff;
        if (cmd.op == lchws_pkg::OP_UPD)
        begin
            res_stat_reg <= stat_new;
            res_key_reg  <= key_rd_reg;
        end
        if (cmd.op == lchws_pkg::OP_OUT)
        begin
            res.status         <= status_reg;
            res.depth_now      <= lchws_pkg::DEPTHO_W'(depth_reg);
            res.result_class   <= has_cls_reg ? lchws_pkg::CLSO_W'(cls_reg) : '0;
            res.out_key        <= has_cls_reg ? res_key_reg : '0;
            res.wait_min_out   <= has_cls_reg ? res_stat_reg.wait_s.min : '0;
            res.wait_max_out   <= has_cls_reg ? res_stat_reg.wait_s.max : '0;
            res.wait_total_out <= has_cls_reg ? res_stat_reg.wait_s.total : '0;
            res.wait_count_out <= has_cls_reg ? res_stat_reg.wait_s.count : '0;
            res.hold_min_out   <= has_cls_reg ? res_stat_reg.hold_s.min : '0;
            res.hold_max_out   <= has_cls_reg ? res_stat_reg.hold_s.max : '0;
            res.hold_total_out <= has_cls_reg ? res_stat_reg.hold_s.total : '0;
            res.hold_count_out <= has_cls_reg ? res_stat_reg.hold_s.count : '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg        <= 1'b0;
            count_reg     <= '0;
            depth_reg     <= '0;
            cptr_reg      <= '0;
            sptr_reg      <= '0;
            cls_reg       <= '0;
            has_cls_reg   <= 1'b0;
            status_reg    <= lchws_pkg::STS_OK;
            upd_wait_reg  <= 1'b0;
            upd_hold_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                en_reg <= cfg.stats_enable;
            if (cmd.op == lchws_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                lchws_pkg::OP_LATCH:
                begin
                    upd_wait_reg <= 1'b0;
                    upd_hold_reg <= 1'b0;
                end
                lchws_pkg::OP_KSTART, lchws_pkg::OP_CLR_START:
                begin
                    cptr_reg    <= '0;
                    has_cls_reg <= 1'b0;
                    status_reg  <= lchws_pkg::STS_OK;
                end
                lchws_pkg::OP_KNEXT, lchws_pkg::OP_CLR:
                begin
                    cptr_reg <= cptr_reg + 1'b1;
                end
                lchws_pkg::OP_KFOUND:
                begin
                    cls_reg     <= cptr_reg;
                    has_cls_reg <= 1'b1;
                    status_reg  <= cmd.code;
                end
                lchws_pkg::OP_KREG:
                begin
                    cls_reg     <= count_reg[CW-1:0];
                    count_reg   <= count_reg + 1'b1;
                    has_cls_reg <= 1'b1;
                    status_reg  <= lchws_pkg::STS_OK;
                end
                lchws_pkg::OP_PUSH:
                begin
                    cls_reg     <= cptr_reg;
                    depth_reg   <= depth_reg + 1'b1;
                    has_cls_reg <= 1'b1;
                    status_reg  <= lchws_pkg::STS_OK;
                end
                lchws_pkg::OP_SSTART:
                begin
                    sptr_reg <= SW'(depth_reg - 1'b1);
                end
                lchws_pkg::OP_SNEXT:
                begin
                    sptr_reg <= sptr_reg - 1'b1;
                end
                lchws_pkg::OP_SHIT:
                begin
                    cls_reg     <= stk_rd_reg.cls;
                    has_cls_reg <= 1'b1;
                    status_reg  <= lchws_pkg::STS_OK;
                    if (cmd_reg == lchws_pkg::CMD_RELEASE)
                    begin
                        upd_hold_reg <= en_reg;
                        depth_reg    <= (SW + 1)'(sptr_reg);
                    end
                    else if (cmd_reg == lchws_pkg::CMD_ACQUIRED)
                    begin
                        upd_wait_reg <= stk_rd_reg.wait_valid && (wait_diff != '0);
                    end
                end
                lchws_pkg::OP_CLSIDX:
                begin
                    cls_reg     <= CW'(cidx_reg);
                    has_cls_reg <= 1'b1;
                    status_reg  <= lchws_pkg::STS_OK;
                end
                lchws_pkg::OP_FAIL:
                begin
                    has_cls_reg <= 1'b0;
                    status_reg  <= cmd.code;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res.valid = out_valid_reg;

    always_comb
    begin
        st.accept     = accept;
        st.command    = cmd_reg;
        st.key_zero   = (key_reg == '0);
        st.stats_en   = en_reg;
        st.count_zero = (count_reg == '0);
        st.tbl_full   = (count_reg >= (CW + 1)'(CLASS_ENTRIES));
        st.stk_empty  = (depth_reg == '0);
        st.stk_full   = (depth_reg >= (SW + 1)'(STACK_ENTRIES));
        st.cidx_bad   = (XW'(cidx_reg) >= XW'(count_reg));
        st.k_match    = (key_rd_reg == key_reg);
        st.k_last     = (((CW + 1)'(cptr_reg) + 1'b1) >= count_reg);
        st.s_match    = (stk_rd_reg.inst == inst_reg);
        st.s_last     = (sptr_reg == '0);
        st.clr_last   = (cptr_reg == CW'(CLASS_ENTRIES - 1));
        st.out_free   = !out_valid_reg || res.ready;
    end

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= (SW + 1)'(STACK_ENTRIES))
        else $error("stack depth overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (CW + 1)'(CLASS_ENTRIES))
        else $error("class count overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == lchws_pkg::OP_PUSH |-> depth_reg < (SW + 1)'(STACK_ENTRIES))
        else $error("push onto full stack");

    a_reg_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == lchws_pkg::OP_KREG |-> count_reg < (CW + 1)'(CLASS_ENTRIES))
        else $error("register into full table");

endmodule
`default_nettype wire

>>> rtl/core/lock_class_hold_wait_stats_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lock_class_hold_wait_stats_top
// Lock class table, held-lock stack and per-class hold/wait statistics.
//
//   channel  dir  handshake     payload
//   evt      in   valid/ready   command, lock_key, lock_instance, timestamp,
//                               class_index
//   res      out  valid/ready   status, class, depth, key, wait/hold stats
//   cfg      in   valid/ready   stats_enable (ready tied high)
//
// One request at a time, in these states: accept, decode, key search (read
// and compare per table entry scanned), stack search (read and compare per
// entry scanned from the top), stats fetch and update, result load. Clear
// stats sweeps every class entry. After reset a sweep zeroes the stats memory;
// ready stays low meanwhile. A new request is taken while a result waits on res.
// ----------------------------------------------------------------------------
module lock_class_hold_wait_stats_top #(
    parameter int CLASS_ENTRIES = lchws_pkg::CLASS_ENTRIES_DEF,
    parameter int STACK_ENTRIES = lchws_pkg::STACK_ENTRIES_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    lchws_evt_if.sink   evt,
    lchws_res_if.source res,
    lchws_cfg_if.sink   cfg
);

    lchws_pkg::dp_cmd_t  cmd;
    lchws_pkg::dp_stat_t st;

    lchws_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    lchws_dp #(
        .CLASS_ENTRIES (CLASS_ENTRIES),
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg),
        .cmd   (cmd),
        .st    (st)
    );

endmodule
`default_nettype wire

>>> dv/lock_class_hold_wait_stats_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_class_hold_wait_stats_top_tb
// Drives lock events through the block, predicts every result from the
// class table, held-lock stack and statistics state, and compares each
// result field by field. A directed table comes first, then random phases
// with varying idle patterns on both channels and stats enable settings.
// ----------------------------------------------------------------------------
module lock_class_hold_wait_stats_top_tb;
    import lchws_pkg::*;

    localparam int NCLS = CLASS_ENTRIES_DEF;
    localparam int NSTK = STACK_ENTRIES_DEF;
    localparam logic [TIME_W-1:0] TMAX = '1;
    // command code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CLSO_W-1:0]   cls;
        logic [DEPTHO_W-1:0] depth;
        logic [KEY_W-1:0]    key;
        stat_t               wait_s;
        stat_t               hold_s;
    } lock_res_t;

    typedef struct {
        int                  cfg_en;   // -1: no config write before this row
        logic [CMD_W-1:0]    cmd;
        logic [KEY_W-1:0]    key;
        logic [INST_W-1:0]   inst;
        logic [TIME_W-1:0]   ts;
        logic [CIDX_W-1:0]   cidx;
        bit                  typed;
        logic [STATUS_W-1:0] status;
    } evt_row_t;

    logic clk;
    logic rst_n;

    lchws_evt_if evt ();
    lchws_res_if res ();
    lchws_cfg_if cfg ();

    lock_class_hold_wait_stats_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

    // shadow state of the block
    logic [KEY_W-1:0]  sh_keys [NCLS];
    int                sh_kcount;
    logic [CIDX_W-1:0] sh_held_cls [NSTK];
    logic [INST_W-1:0] sh_held_inst [NSTK];
    logic [TIME_W-1:0] sh_wait_stamp [NSTK];
    bit                sh_wait_valid [NSTK];
    logic [TIME_W-1:0] sh_hold_stamp [NSTK];
    int                sh_depth;
    stat_t             sh_wait [NCLS];
    stat_t             sh_hold [NCLS];
    bit                sh_enable;

    lock_res_t expected_results [$];
    int        fails;
    int        idle_mode;
    logic [KEY_W-1:0]  key_pool [80];
    logic [TIME_W-1:0] now_ts;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("lock_class_hold_wait_stats_top_tb failed");
        $finish;
    end

    function automatic stat_t stat_record(stat_t s, logic [TIME_W-1:0] t);
        stat_t r;
        r = s;
        if (t < s.min || s.count == 0)
            r.min = t;
        if (t > s.max)
            r.max = t;
        r.total = s.total + {16'd0, t};
        if (s.count != 32'hFFFF_FFFF)
            r.count = s.count + 32'd1;
        return r;
    endfunction

    function automatic lock_res_t predict_lock_event(logic [CMD_W-1:0] cmd,
            logic [KEY_W-1:0] key, logic [INST_W-1:0] inst,
            logic [TIME_W-1:0] ts, logic [CIDX_W-1:0] cidx);
        lock_res_t r;
        int cls;
        int pos;
        bit has_cls;
        logic [TIME_W-1:0] dt;
        r = '0;
        cls = -1;
        pos = -1;
        has_cls = 0;
        r.status = STS_OK;
        if (cmd == CMD_REGISTER || cmd == CMD_ACQUIRE)
            for (int i = 0; i < sh_kcount; i++)
                if (cls < 0 && sh_keys[i] == key)
                    cls = i;
        if (cmd == CMD_RELEASE || cmd == CMD_CONTENDED || cmd == CMD_ACQUIRED)
            for (int i = sh_depth - 1; i >= 0; i--)
                if (pos < 0 && sh_held_inst[i] == inst)
                    pos = i;
        case (cmd)
            CMD_REGISTER:
                if (key == 0)
                    r.status = STS_NULL_KEY;
                else if (cls >= 0)
                begin
                    r.status = STS_DUPLICATE;
                    has_cls = 1;
                end
                else if (sh_kcount >= NCLS)
                    r.status = STS_TBL_FULL;
                else
                begin
                    cls = sh_kcount;
                    sh_keys[cls] = key;
                    sh_kcount++;
                    has_cls = 1;
                end
            CMD_ACQUIRE:
                if (key == 0)
                    r.status = STS_NULL_KEY;
                else if (cls < 0)
                    r.status = STS_UNKNOWN;
                else if (sh_depth >= NSTK)
                    r.status = STS_STK_FULL;
                else
                begin
                    has_cls = 1;
                    sh_held_cls[sh_depth] = CIDX_W'(cls);
                    sh_held_inst[sh_depth] = inst;
                    sh_wait_stamp[sh_depth] = '0;
                    sh_wait_valid[sh_depth] = 0;
                    sh_hold_stamp[sh_depth] = ts;
                    sh_depth++;
                end
            CMD_RELEASE, CMD_CONTENDED, CMD_ACQUIRED:
                if (cmd != CMD_RELEASE && !sh_enable)
                    r.status = STS_DISABLED;
                else if (sh_depth == 0)
                    r.status = STS_STK_EMPTY;
                else if (pos < 0)
                    r.status = STS_NOT_HELD;
                else
                begin
                    cls = sh_held_cls[pos];
                    has_cls = 1;
                    if (cmd == CMD_RELEASE)
                    begin
                        if (sh_enable)
                            sh_hold[cls] = stat_record(sh_hold[cls], ts - sh_hold_stamp[pos]);
                        sh_depth = pos;
                    end
                    else if (cmd == CMD_CONTENDED)
                    begin
                        sh_wait_stamp[pos] = ts;
                        sh_wait_valid[pos] = 1;
                    end
                    else if (sh_wait_valid[pos])
                    begin
                        dt = ts - sh_wait_stamp[pos];
                        sh_hold_stamp[pos] = ts;
                        if (dt != 0)
                            sh_wait[cls] = stat_record(sh_wait[cls], dt);
                    end
                end
            CMD_READ:
                if (cidx >= sh_kcount)
                    r.status = STS_BAD_INDEX;
                else
                begin
                    cls = cidx;
                    has_cls = 1;
                end
            CMD_CLEAR:
                for (int i = 0; i < NCLS; i++)
                begin
                    sh_wait[i] = '0;
                    sh_hold[i] = '0;
                end
            default: ;
        endcase
        r.depth = DEPTHO_W'(sh_depth);
        if (has_cls)
        begin
            r.cls = CLSO_W'(cls);
            r.key = sh_keys[cls];
            r.wait_s = sh_wait[cls];
            r.hold_s = sh_hold[cls];
        end
        return r;
    endfunction

    function automatic bit sender_idle();
        return (idle_mode == 1 && $urandom_range(0, 99) < 77) ||
               (idle_mode == 3 && $urandom_range(0, 99) < 29);
    endfunction

    // result ready, toggled at the falling edge
    always @(negedge clk)
        res.ready <= !((idle_mode == 2 && $urandom_range(0, 99) < 77) ||
                       (idle_mode == 3 && $urandom_range(0, 99) < 29));

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk)
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending");
                fails++;
            end
            else
            begin
                lock_res_t e;
                e = expected_results.pop_front();
                check_field("status", e.status, res.status);
                check_field("result_class", e.cls, res.result_class);
                check_field("depth_now", e.depth, res.depth_now);
                check_field("out_key", e.key, res.out_key);
                check_field("wait_min_out", e.wait_s.min, res.wait_min_out);
                check_field("wait_max_out", e.wait_s.max, res.wait_max_out);
                check_field("wait_total_out", e.wait_s.total, res.wait_total_out);
                check_field("wait_count_out", e.wait_s.count, res.wait_count_out);
                check_field("hold_min_out", e.hold_s.min, res.hold_min_out);
                check_field("hold_max_out", e.hold_s.max, res.hold_max_out);
                check_field("hold_total_out", e.hold_s.total, res.hold_total_out);
                check_field("hold_count_out", e.hold_s.count, res.hold_count_out);
            end
        end

    // starts and ends at a falling edge; valid stays high for the next request
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
            logic [INST_W-1:0] inst, logic [TIME_W-1:0] ts, logic [CIDX_W-1:0] cidx,
            bit typed, logic [STATUS_W-1:0] typed_status);
        lock_res_t e;
        while (sender_idle())
        begin
            evt.valid = 1'b0;
            @(negedge clk);
        end
        evt.valid = 1'b1;
        evt.command = cmd;
        evt.lock_key = key;
        evt.lock_instance = inst;
        evt.timestamp = ts;
        evt.class_index = cidx;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        e = predict_lock_event(cmd, key, inst, ts, cidx);
        if (typed)
            e.status = typed_status;
        expected_results.push_back(e);
        @(negedge clk);
    endtask

    task automatic drain();
        evt.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_enable(bit en);
        drain();
        cfg.valid = 1'b1;
        cfg.stats_enable = en;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sh_enable = en;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    task automatic send_random(bit reg_heavy);
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [INST_W-1:0] inst;
        logic [CIDX_W-1:0] cidx;
        int sel;
        sel = $urandom_range(0, 99);
        if (reg_heavy)
            cmd = (sel < 70) ? CMD_REGISTER : CMD_ACQUIRE;
        else if (sel < 8)
            cmd = CMD_REGISTER;
        else if (sel < 38)
            cmd = CMD_ACQUIRE;
        else if (sel < 58)
            cmd = CMD_RELEASE;
        else if (sel < 72)
            cmd = CMD_CONTENDED;
        else if (sel < 86)
            cmd = CMD_ACQUIRED;
        else if (sel < 95)
            cmd = CMD_READ;
        else if (sel < 97)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            key = '0;
        else if (sel < 8)
            key = $urandom();
        else if (cmd == CMD_ACQUIRE && sh_kcount > 0)
            key = sh_keys[$urandom_range(0, sh_kcount - 1)];
        else
            key = key_pool[$urandom_range(0, 79)];
        if (sh_depth > 0 && $urandom_range(0, 99) < 80)
            inst = sh_held_inst[$urandom_range(0, sh_depth - 1)];
        else if ($urandom_range(0, 1))
            inst = $urandom_range(0, 15);
        else
            inst = $urandom();
        if ($urandom_range(0, 99) < 85 && sh_kcount > 0)
            cidx = CIDX_W'($urandom_range(0, sh_kcount - 1));
        else
            cidx = CIDX_W'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 6)
            now_ts = rand_time();
        else
            now_ts = now_ts + $urandom_range(0, 60);
        send_request(cmd, key, inst, now_ts, cidx, 0, STS_OK);
    endtask

    evt_row_t directed [] = '{
        '{-1, CMD_READ,      32'd0,        32'd0,        48'd0,   6'd0,  1, STS_BAD_INDEX},
        '{-1, CMD_RELEASE,   32'd0,        32'd0,        48'd0,   6'd0,  1, STS_STK_EMPTY},
        '{-1, CMD_CONTENDED, 32'd0,        32'd0,        48'd0,   6'd0,  1, STS_DISABLED},
        '{-1, CMD_REGISTER,  32'd0,        32'd0,        48'd0,   6'd0,  1, STS_NULL_KEY},
        '{-1, CMD_ACQUIRE,   32'd0,        32'd0,        48'd0,   6'd0,  1, STS_NULL_KEY},
        '{-1, CMD_ACQUIRE,   32'd5,        32'd0,        48'd0,   6'd0,  1, STS_UNKNOWN},
        '{-1, CMD_REGISTER,  32'hFFFFFFFF, 32'd0,        48'd0,   6'd0,  1, STS_OK},
        '{-1, CMD_REGISTER,  32'hFFFFFFFF, 32'd0,        48'd0,   6'd0,  1, STS_DUPLICATE},
        '{-1, CMD_REGISTER,  32'd1,        32'd0,        48'd0,   6'd0,  1, STS_OK},
        '{-1, CMD_ACQUIRE,   32'hFFFFFFFF, 32'd0,        48'd0,   6'd0,  1, STS_OK},
        '{-1, CMD_ACQUIRE,   32'd1,        32'hFFFFFFFF, TMAX,    6'd0,  1, STS_OK},
        '{-1, CMD_RELEASE,   32'd0,        32'd7,        48'd5,   6'd0,  1, STS_NOT_HELD},
        '{-1, CMD_RELEASE,   32'd0,        32'hFFFFFFFF, 48'd9,   6'd0,  0, STS_OK},
        '{-1, CMD_READ,      32'd0,        32'd0,        48'd0,   6'd63, 1, STS_BAD_INDEX},
        '{-1, CMD_CLEAR,     32'd0,        32'd0,        48'd0,   6'd0,  1, STS_OK},
        '{-1, CMD_UNUSED,    32'd0,        32'd0,        48'd0,   6'd0,  1, STS_OK},
        '{ 1, CMD_ACQUIRE,   32'hFFFFFFFF, 32'd0,        48'd100, 6'd0,  0, STS_OK},
        '{-1, CMD_ACQUIRED,  32'd0,        32'd0,        48'd120, 6'd0,  0, STS_OK},
        '{-1, CMD_CONTENDED, 32'd0,        32'd0,        48'd150, 6'd0,  0, STS_OK},
        '{-1, CMD_ACQUIRED,  32'd0,        32'd0,        48'd150, 6'd0,  0, STS_OK},
        '{-1, CMD_ACQUIRED,  32'd0,        32'd0,        48'd170, 6'd0,  0, STS_OK},
        '{-1, CMD_RELEASE,   32'd0,        32'd0,        48'd10,  6'd0,  0, STS_OK},
        '{-1, CMD_ACQUIRED,  32'd0,        32'd0,        48'd10,  6'd0,  0, STS_OK},
        '{-1, CMD_READ,      32'd0,        32'd0,        48'd0,   6'd1,  0, STS_OK}
    };

    initial
    begin
        fails = 0;
        idle_mode = 0;
        now_ts = '0;
        sh_kcount = 0;
        sh_depth = 0;
        sh_enable = 0;
        for (int i = 0; i < NCLS; i++)
        begin
            sh_keys[i] = '0;
            sh_wait[i] = '0;
            sh_hold[i] = '0;
        end
        key_pool[0] = 32'hFFFFFFFF;
        for (int i = 1; i < 80; i++)
            key_pool[i] = $urandom() | 32'd1;
        rst_n = 1'b0;
        evt.valid = 1'b0;
        evt.command = CMD_REGISTER;
        evt.lock_key = '0;
        evt.lock_instance = '0;
        evt.timestamp = '0;
        evt.class_index = '0;
        cfg.valid = 1'b0;
        cfg.stats_enable = 1'b0;
        res.ready = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].cfg_en >= 0)
                write_enable(directed[i].cfg_en[0]);
            send_request(directed[i].cmd, directed[i].key, directed[i].inst,
                         directed[i].ts, directed[i].cidx, directed[i].typed,
                         directed[i].status);
        end

        for (int p = 0; p < 8; p++)
        begin
            idle_mode = p % 4;
            write_enable((p == 2 || p == 5) ? 1'b0 : 1'b1);
            for (int n = 0; n < 80; n++)
            begin
                // fill the class table early, and push the stack in phase 3
                send_random(p == 1 || (p == 3 && n < 40 && $urandom_range(0, 3) != 0));
                if (n == 40 && p == 4)
                begin
                    evt.valid = 1'b0;
                    while (expected_results.size() != 0)
                        @(negedge clk);
                end
            end
        end

        evt.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fails == 0)
            $display("lock_class_hold_wait_stats_top_tb passed");
        else
            $display("lock_class_hold_wait_stats_top_tb failed");
        $finish;
    end

endmodule
